>>> rtl/core/tile_background_window_pixel_assert.svh
// Assertion macros shared by the tile background and window pixel RTL.
`ifndef TILE_BACKGROUND_WINDOW_PIXEL_ASSERT_SVH
`define TILE_BACKGROUND_WINDOW_PIXEL_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define TBWP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define TBWP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/tbwp_pkg.sv
// Package with the types, constants and color tables of the tile pixel generator.
`timescale 1ns / 1ps
`default_nettype none

package tbwp_pkg;

	localparam int VRAM_BYTES = 8192;
	localparam int VRAM_AW    = $clog2(VRAM_BYTES);
	localparam int BANK_AW    = VRAM_AW - 1;

	localparam logic [VRAM_AW-1:0] MAP_LOW_BASE     = 13'h1800;
	localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE    = 13'h1C00;
	localparam logic [VRAM_AW-1:0] TILE_SIGNED_BASE = 13'h0800;

	localparam logic [7:0] WIN_X_MAX  = 8'd166;
	localparam logic [7:0] LINE_MAX   = 8'd143;
	localparam logic [7:0] SIGN_FLIP  = 8'h80;
	localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

	// Bit positions inside the LCD control register.
	localparam int LCDC_BG_ON    = 0;
	localparam int LCDC_BG_MAP   = 3;
	localparam int LCDC_UNSIGNED = 4;
	localparam int LCDC_WIN_ON   = 5;
	localparam int LCDC_WIN_MAP  = 6;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_RENDER = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_LCD_CONTROL   = 3'd0,
		REG_SCROLL_X      = 3'd1,
		REG_SCROLL_Y      = 3'd2,
		REG_BG_PALETTE    = 3'd3,
		REG_WINDOW_X      = 3'd4,
		REG_WINDOW_Y      = 3'd5,
		REG_GREEN_PALETTE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		op_t                op;
		logic [VRAM_AW-1:0] vram_addr;
		logic [7:0]         vram_data;
		logic [7:0]         line;
		logic [7:0]         screen_x;
		logic [7:0]         window_line;
	} in_t;

	typedef struct packed {
		logic [1:0]  shade;
		logic [23:0] rgb;
	} out_t;

	// Maps a 2-bit shade to RGB through the green or the grey table.
	function automatic logic [23:0] shade_rgb(input logic green, input logic [1:0] shade);
		logic [23:0] rgb;
		rgb = RGB_WHITE;
		if (green) begin
			case (shade)
				2'd0:    rgb = 24'hD1F7E1;
				2'd1:    rgb = 24'h72C387;
				2'd2:    rgb = 24'h537033;
				default: rgb = 24'h212009;
			endcase
		end else begin
			case (shade)
				2'd0:    rgb = 24'hFFFFFF;
				2'd1:    rgb = 24'hAAAAAA;
				2'd2:    rgb = 24'h555555;
				default: rgb = 24'h000000;
			endcase
		end
		return rgb;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/tile_background_window_pixel.sv
// Top level of the tile background and window pixel generator with its video memory.
`timescale 1ns / 1ps
`default_nettype none

// The block owns an 8 KiB video memory and turns render requests into one
// pixel each, at a sustained rate of one request per clock cycle while the
// output side is not stalling. A write request stores one byte and yields no
// result; a render request yields one shade and RGB value by way of stage 1,
// stage 2 and the output register. The rate is set by the video memory,
// which is split into an even and an odd byte bank with two read ports each:
// one port serves the tile map lookup of the younger request while the other
// fetches one bit plane of the tile row for the older one, so the two
// dependent reads of a pixel run as pipeline stages and never compete. Writes
// land at the moment they are accepted, so a render request always sees every
// write that came before it and none that came after. After reset the block
// sweeps the memory to zero, one byte pair per cycle over all 4096 pairs;
// meanwhile in_ready is low while configuration writes are still taken.
// Configuration should only be changed while no render request is in flight.
module tile_background_window_pixel (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire tbwp_pkg::in_t           in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output tbwp_pkg::out_t               out_data,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [7:0]              cfg_data
);

	import tbwp_pkg::*;

	`include "tile_background_window_pixel_assert.svh"

	localparam int BANK_DEPTH = VRAM_BYTES / 2;

	// Configuration registers.
	logic [7:0] lcd_control_q;
	logic [7:0] scroll_x_q;
	logic [7:0] scroll_y_q;
	logic [7:0] bg_palette_q;
	logic [7:0] window_x_q;
	logic [7:0] window_y_q;
	logic       green_palette_q;

	// Video memory, split by address bit 0.
	logic [7:0] mem_even_q [BANK_DEPTH];
	logic [7:0] mem_odd_q  [BANK_DEPTH];

	// Clearing sweep after reset.
	logic               clearing_q;
	logic [BANK_AW-1:0] clear_idx_q;

	// Pipeline control.
	logic accept;
	logic en_s1;
	logic en_s2;
	logic en_out;

	// Map lookup, computed from the request as it is accepted.
	logic [8:0]         sx_plus7;
	logic               win_hit;
	logic               have_pix;
	logic [7:0]         tile_x;
	logic [7:0]         tile_y;
	logic               map_high;
	logic [VRAM_AW-1:0] map_addr;

	// Write port.
	logic               we_even;
	logic               we_odd;
	logic [BANK_AW-1:0] wr_idx;
	logic [7:0]         wr_byte;

	// Stage 1: map entry read back, tile row address formed.
	logic               valid_s1;
	logic               have_s1;
	logic [2:0]         px_s1;
	logic [2:0]         py_s1;
	logic               map_sel_s1;
	logic [7:0]         map_even_s1;
	logic [7:0]         map_odd_s1;
	logic [7:0]         tile_entry;
	logic [VRAM_AW-1:0] tile_addr;
	logic [BANK_AW-1:0] tile_idx;

	// Stage 2: both bit planes of the tile row read back.
	logic       valid_s2;
	logic       have_s2;
	logic [2:0] px_s2;
	logic [7:0] tile_lo_s2;
	logic [7:0] tile_hi_s2;
	logic [2:0] bit_pos;
	logic [1:0] colour;
	logic [1:0] shade;
	out_t       pix;

	// Output register.
	logic out_valid_q;
	out_t out_data_q;

	// A stage takes new contents when it is empty or its successor moves.
	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = en_out || !valid_s2;
	assign en_s1    = en_s2 || !valid_s1;
	assign in_ready = en_s1 && !clearing_q;
	assign accept   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	// The window wins when it is enabled, on screen and left of the pixel.
	always_comb begin
		sx_plus7 = {1'b0, in_data.screen_x} + 9'd7;
		win_hit  = lcd_control_q[LCDC_WIN_ON] && (window_x_q <= WIN_X_MAX) &&
			(window_y_q <= LINE_MAX) && (in_data.window_line <= LINE_MAX) &&
			(in_data.line >= window_y_q) && (sx_plus7 >= {1'b0, window_x_q});
		have_pix = win_hit || lcd_control_q[LCDC_BG_ON];
		if (win_hit) begin
			tile_x   = 8'(sx_plus7 - {1'b0, window_x_q});
			tile_y   = in_data.window_line;
			map_high = lcd_control_q[LCDC_WIN_MAP];
		end else begin
			tile_x   = scroll_x_q + in_data.screen_x;
			tile_y   = scroll_y_q + in_data.line;
			map_high = lcd_control_q[LCDC_BG_MAP];
		end
		map_addr = (map_high ? MAP_HIGH_BASE : MAP_LOW_BASE) |
			{3'b000, tile_y[7:3], tile_x[7:3]};
	end

	// The sweep writes zero to both banks; a write request hits one bank.
	always_comb begin
		if (clearing_q) begin
			we_even = 1'b1;
			we_odd  = 1'b1;
			wr_idx  = clear_idx_q;
			wr_byte = 8'h00;
		end else begin
			we_even = accept && (in_data.op == OP_WRITE) && !in_data.vram_addr[0];
			we_odd  = accept && (in_data.op == OP_WRITE) && in_data.vram_addr[0];
			wr_idx  = in_data.vram_addr[VRAM_AW-1:1];
			wr_byte = in_data.vram_data;
		end
	end

	// Both banks share one index for the map read; the entry is picked in stage 1.
	always_ff @(posedge clk) begin
		if (we_even) begin
			mem_even_q[wr_idx] <= wr_byte;
		end
		if (en_s1) begin
			map_even_s1 <= mem_even_q[map_addr[VRAM_AW-1:1]];
		end
		if (en_s2) begin
			tile_lo_s2 <= mem_even_q[tile_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (we_odd) begin
			mem_odd_q[wr_idx] <= wr_byte;
		end
		if (en_s1) begin
			map_odd_s1 <= mem_odd_q[map_addr[VRAM_AW-1:1]];
		end
		if (en_s2) begin
			tile_hi_s2 <= mem_odd_q[tile_idx];
		end
	end

	// Tile rows are byte pairs, so the low plane is even and the high plane odd.
	always_comb begin
		tile_entry = map_sel_s1 ? map_odd_s1 : map_even_s1;
		if (lcd_control_q[LCDC_UNSIGNED]) begin
			tile_addr = {1'b0, tile_entry, 4'b0000};
		end else begin
			tile_addr = TILE_SIGNED_BASE + {1'b0, tile_entry ^ SIGN_FLIP, 4'b0000};
		end
		tile_idx = {tile_addr[VRAM_AW-1:4], py_s1};
	end

	// Pixel column c sits in bit 7 - c of both planes.
	always_comb begin
		bit_pos   = 3'd7 - px_s2;
		colour    = {tile_hi_s2[bit_pos], tile_lo_s2[bit_pos]};
		shade     = bg_palette_q[{colour, 1'b0} +: 2];
		if (have_s2) begin
			pix.shade = shade;
			pix.rgb   = shade_rgb(green_palette_q, shade);
		end else begin
			pix.shade = 2'd0;
			pix.rgb   = RGB_WHITE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= accept && (in_data.op == OP_RENDER);
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			have_s1    <= have_pix;
			px_s1      <= tile_x[2:0];
			py_s1      <= tile_y[2:0];
			map_sel_s1 <= map_addr[0];
		end
		if (en_s2) begin
			have_s2 <= have_s1;
			px_s2   <= px_s1;
		end
		if (en_out) begin
			out_data_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clear_idx_q <= '0;
		end else if (clearing_q) begin
			clear_idx_q <= clear_idx_q + BANK_AW'(1);
			if (clear_idx_q == BANK_AW'(BANK_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_control_q   <= '0;
			scroll_x_q      <= '0;
			scroll_y_q      <= '0;
			bg_palette_q    <= '0;
			window_x_q      <= '0;
			window_y_q      <= '0;
			green_palette_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LCD_CONTROL:   lcd_control_q   <= cfg_data;
				REG_SCROLL_X:      scroll_x_q      <= cfg_data;
				REG_SCROLL_Y:      scroll_y_q      <= cfg_data;
				REG_BG_PALETTE:    bg_palette_q    <= cfg_data;
				REG_WINDOW_X:      window_x_q      <= cfg_data;
				REG_WINDOW_Y:      window_y_q      <= cfg_data;
				REG_GREEN_PALETTE: green_palette_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// No request may slip in while the memory is still being cleared.
	`TBWP_ASSERT_ALWAYS(a_no_accept_while_clearing, clearing_q |-> !in_ready, "request accepted during clear")
	// An accepted render request must occupy stage 1 on the next cycle.
	`TBWP_ASSERT(a_render_enters_s1, (accept && in_data.op == OP_RENDER) |=> valid_s1, "render request lost at stage 1")
	// A stalled tile fetch must keep its item and its column.
	`TBWP_ASSERT(a_s2_holds, (valid_s2 && !en_s2) |=> (valid_s2 && $stable(px_s2) && $stable(tile_lo_s2)), "stalled stage 2 changed")
	// The sweep ends only after visiting the last entry.
	`TBWP_ASSERT(a_clear_completes, $fell(clearing_q) |-> ($past(clear_idx_q) == BANK_AW'(BANK_DEPTH - 1)), "clear ended early")

endmodule

`default_nettype wire

>>> tb/tile_background_window_pixel_test.sv
// Self-checking testbench for the tile background and window pixel generator.
`timescale 1ns / 1ps

module tile_background_window_pixel_test;
	import tbwp_pkg::*;

	// Generous bound on the run: the memory sweep after reset plus every
	// request paying the longest sender gap and the longest output stall.
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	// Cycles left for a write request to settle before the registers change.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_REQUESTS = 128;

	// Shade to color tables; index 0 is the rightmost entry.
	localparam logic [3:0][23:0] GREEN_RGB = {24'h212009, 24'h537033, 24'h72C387, 24'hD1F7E1};
	localparam logic [3:0][23:0] GREY_RGB  = {24'h000000, 24'h555555, 24'hAAAAAA, 24'hFFFFFF};

	// One full register setting, field for field as the block keeps it.
	typedef struct packed {
		logic [7:0] lcdc;
		logic [7:0] scx;
		logic [7:0] scy;
		logic [7:0] pal;
		logic [7:0] wx;
		logic [7:0] wy;
		logic       green;
	} reg_set_t;

	typedef enum logic {
		STEP_REGS,
		STEP_REQUEST
	} step_kind_t;

	// One row of the directed table: either a new register setting or a
	// request, where a render request may carry the pixel it must produce.
	typedef struct {
		step_kind_t kind;
		reg_set_t   regs;
		in_t        req;
		bit         known;
		out_t       want;
	} stim_step_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_HOLD
	} rx_mode_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	// Our own copy of the video memory and the registers, kept in step with
	// every accepted write request and every accepted register write.
	logic [7:0] shadow_vram [0:VRAM_BYTES-1];
	reg_set_t   active_regs = '0;

	out_t       pending_pixels[$];
	stim_step_t steps[$];

	int fault_count = 0;
	int cycle_count = 0;
	int burst_left  = 1;

	rx_mode_t rx_mode   = RX_OPEN;
	int       mode_left = 0;
	int       hold_left = 0;
	logic [2:0] rx_phase = '0;

	tile_background_window_pixel DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Looks up the 2-bit color of one tile pixel. The map coordinates wrap at
	// 32 tiles, which is the same as wrapping the pixel position at 256, so the
	// 8-bit pixel position carries everything that matters.
	function automatic logic [1:0] fetch_colour(input logic [12:0] map_base,
			input logic [7:0] fx, input logic [7:0] fy);
		logic [7:0]  entry;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [12:0] tile_base;
		logic [12:0] row_addr;
		logic [2:0]  bit_pos;
		entry = shadow_vram[map_base + {3'b000, fy[7:3], fx[7:3]}];
		// Unsigned mode counts tiles from address zero; signed mode centers the
		// index on the middle of the tile data area.
		if (active_regs.lcdc[LCDC_UNSIGNED]) begin
			tile_base = {1'b0, entry, 4'b0000};
		end else begin
			tile_base = TILE_SIGNED_BASE + {1'b0, entry ^ SIGN_FLIP, 4'b0000};
		end
		row_addr = tile_base + {9'd0, fy[2:0], 1'b0};
		lo = shadow_vram[row_addr];
		hi = shadow_vram[row_addr + 13'd1];
		bit_pos = 3'd7 - fx[2:0];
		return {hi[bit_pos], lo[bit_pos]};
	endfunction

	// Works out the pixel that a render request must produce under the
	// current registers and memory contents.
	function automatic out_t render_pixel(input in_t req);
		out_t       pix;
		logic [7:0] fx;
		logic [7:0] fy;
		logic [1:0] colour;
		logic [1:0] shade;
		bit         drawn;
		drawn  = 1'b0;
		colour = 2'd0;
		// The window wins whenever it is switched on, placed on screen, and the
		// pixel lies at or right of its edge and at or below its top line.
		if (active_regs.lcdc[LCDC_WIN_ON] && active_regs.wx <= WIN_X_MAX &&
				active_regs.wy <= LINE_MAX && req.window_line <= LINE_MAX &&
				req.line >= active_regs.wy &&
				int'(req.screen_x) + 7 >= int'(active_regs.wx)) begin
			fx = 8'(int'(req.screen_x) + 7 - int'(active_regs.wx));
			colour = fetch_colour(active_regs.lcdc[LCDC_WIN_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE,
				fx, req.window_line);
			drawn = 1'b1;
		end else if (active_regs.lcdc[LCDC_BG_ON]) begin
			fx = active_regs.scx + req.screen_x;
			fy = active_regs.scy + req.line;
			colour = fetch_colour(active_regs.lcdc[LCDC_BG_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE,
				fx, fy);
			drawn = 1'b1;
		end
		if (drawn) begin
			shade = active_regs.pal[{colour, 1'b0} +: 2];
			pix.shade = shade;
			pix.rgb = active_regs.green ? GREEN_RGB[shade] : GREY_RGB[shade];
		end else begin
			// With neither layer drawn the pixel is plain white.
			pix.shade = 2'd0;
			pix.rgb = RGB_WHITE;
		end
		return pix;
	endfunction

	function automatic void add_regs(input logic [7:0] lcdc, input logic [7:0] scx,
			input logic [7:0] scy, input logic [7:0] pal, input logic [7:0] wx,
			input logic [7:0] wy, input logic green);
		stim_step_t s;
		s.kind = STEP_REGS;
		s.regs = '{lcdc: lcdc, scx: scx, scy: scy, pal: pal, wx: wx, wy: wy, green: green};
		s.req = '0;
		s.known = 1'b0;
		s.want = '0;
		steps.push_back(s);
	endfunction

	function automatic void add_write(input logic [12:0] addr, input logic [7:0] value);
		stim_step_t s;
		s.kind = STEP_REQUEST;
		s.regs = '0;
		s.req = '0;
		s.req.op = OP_WRITE;
		s.req.vram_addr = addr;
		s.req.vram_data = value;
		s.known = 1'b0;
		s.want = '0;
		steps.push_back(s);
	endfunction

	// A render row; when known is set the expected pixel is the one given.
	function automatic void add_render(input logic [7:0] ln, input logic [7:0] sx,
			input logic [7:0] wl, input bit known = 1'b0, input logic [1:0] shade = 2'd0,
			input logic [23:0] rgb = 24'd0);
		stim_step_t s;
		s.kind = STEP_REQUEST;
		s.regs = '0;
		s.req = '0;
		s.req.op = OP_RENDER;
		s.req.line = ln;
		s.req.screen_x = sx;
		s.req.window_line = wl;
		s.known = known;
		s.want.shade = shade;
		s.want.rgb = rgb;
		steps.push_back(s);
	endfunction

	// Presents one request and holds it until it is taken. Expectations are
	// formed at acceptance, in request order, so a render sees exactly the
	// writes that went before it. The sender then either keeps valid high for
	// the next request of the burst or drops it for a random gap.
	task automatic send_request(input in_t req, input bit known, input out_t want);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		if (req.op == OP_RENDER) begin
			pending_pixels.push_back(known ? want : render_pixel(req));
		end else begin
			shadow_vram[req.vram_addr] = req.vram_data;
		end
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// One burst in four is a long stretch without any idling.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
				: $urandom_range(1, 16);
		end
	endtask

	// Writes one register and leaves valid high so that several writes can
	// follow each other without a gap.
	task automatic write_register(input cfg_reg_t which, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			REG_LCD_CONTROL:   active_regs.lcdc = value;
			REG_SCROLL_X:      active_regs.scx = value;
			REG_SCROLL_Y:      active_regs.scy = value;
			REG_BG_PALETTE:    active_regs.pal = value;
			REG_WINDOW_X:      active_regs.wx = value;
			REG_WINDOW_Y:      active_regs.wy = value;
			REG_GREEN_PALETTE: active_regs.green = value[0];
			default: ;
		endcase
	endtask

	// Changes the registers only once the block has gone idle: every render
	// has come back and a trailing write has had time to land.
	task automatic load_registers(input reg_set_t regs);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_LCD_CONTROL, regs.lcdc);
		write_register(REG_SCROLL_X, regs.scx);
		write_register(REG_SCROLL_Y, regs.scy);
		write_register(REG_BG_PALETTE, regs.pal);
		write_register(REG_WINDOW_X, regs.wx);
		write_register(REG_WINDOW_Y, regs.wy);
		write_register(REG_GREEN_PALETTE, {7'd0, regs.green});
		cfg_valid <= 1'b0;
	endtask

	// The output side switches at random between stall patterns: always
	// ready, a coin toss per cycle, a fixed duty cycle, or rare long holds.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(100, 600);
		end else begin
			mode_left <= mode_left - 1;
		end
		rx_phase <= rx_phase + 3'd1;
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_ready <= (rx_phase < 3'd5);
			RX_HOLD: begin
				if (hold_left != 0) begin
					out_ready <= 1'b0;
					hold_left <= hold_left - 1;
				end else if ($urandom_range(0, 11) == 0) begin
					out_ready <= 1'b0;
					hold_left <= $urandom_range(1, 19);
				end else begin
					out_ready <= 1'b1;
				end
			end
			default: out_ready <= 1'b1;
		endcase
	end

	// Every pixel taken from the block is matched against the oldest expected
	// pixel, shade and color separately.
	always @(posedge clk) begin : check_pixels
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX) begin
					$display("unexpected pixel: shade %0d rgb %06h", out_data.shade,
						out_data.rgb);
				end
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.shade !== want.shade || out_data.rgb !== want.rgb) begin
					fault_count++;
					if (fault_count <= REPORT_MAX) begin
						$display("pixel mismatch: expected shade %0d rgb %06h, got shade %0d rgb %06h",
							want.shade, want.rgb, out_data.shade, out_data.rgb);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		reg_set_t         regs;
		in_t              req;
		logic [3:0][7:0]  hot;
		logic [7:0]       tile;
		int               pick;

		foreach (shadow_vram[i]) shadow_vram[i] = 8'h00;
		burst_left = $urandom_range(1, 16);

		// Hold reset before releasing it. The block then sweeps its memory, which
		// shows up as a long stretch of in_ready low.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Right after reset both layers are off, so the first
		// pixels are white whatever the coordinates, extremes included.
		add_render(8'd0, 8'd0, 8'd0, 1'b1, 2'd0, RGB_WHITE);
		add_render(8'd143, 8'd159, 8'd143, 1'b1, 2'd0, RGB_WHITE);
		// Background on, low map, signed tile data: the cleared memory gives
		// color 0 everywhere.
		add_regs(8'h01, 8'd0, 8'd0, 8'hE4, 8'd0, 8'd0, 1'b0);
		add_render(8'd0, 8'd0, 8'd0);
		// Map entry 0x80 in signed mode points at the first tile of the
		// signed area; give its top row a mix of all four colors.
		add_write(MAP_LOW_BASE, 8'h80);
		add_write(TILE_SIGNED_BASE, 8'hF0);
		add_write(TILE_SIGNED_BASE + 13'd1, 8'h3C);
		add_render(8'd0, 8'd0, 8'd0);
		add_render(8'd0, 8'd2, 8'd0);
		add_render(8'd0, 8'd7, 8'd0);
		// Both ends of the address range.
		add_write(13'h1FFF, 8'hFF);
		add_write(13'h0000, 8'hA5);
		// High map, unsigned data, scroll at its maximum so that the map wraps
		// around in both directions; green colors.
		add_regs(8'h19, 8'hFF, 8'hFF, 8'h1B, 8'd0, 8'd0, 1'b1);
		add_render(8'd0, 8'd0, 8'd0);
		add_render(8'd1, 8'd1, 8'd0);
		add_render(8'd143, 8'd159, 8'd0);
		// Window alone, with the background off: the window still draws.
		add_regs(8'h20, 8'd0, 8'd0, 8'hE4, 8'd7, 8'd0, 1'b0);
		add_render(8'd0, 8'd0, 8'd0);
		// A window line past the screen hides the window; nothing is drawn.
		add_render(8'd0, 8'd0, 8'd144, 1'b1, 2'd0, RGB_WHITE);
		// Window at its right and bottom limits, on the high map.
		add_regs(8'h61, 8'd0, 8'd0, 8'hE4, 8'd166, 8'd143, 1'b0);
		add_render(8'd143, 8'd159, 8'd0);
		add_render(8'd143, 8'd158, 8'd0);
		add_render(8'd142, 8'd159, 8'd0);
		// Window placed just past the right limit, then just past the bottom
		// limit: with the background off both leave the pixel white.
		add_regs(8'h20, 8'd0, 8'd0, 8'hFF, 8'd167, 8'd0, 1'b1);
		add_render(8'd0, 8'd159, 8'd0, 1'b1, 2'd0, RGB_WHITE);
		add_regs(8'h20, 8'd0, 8'd0, 8'hFF, 8'd0, 8'd144, 1'b1);
		add_render(8'd200, 8'd10, 8'd0, 1'b1, 2'd0, RGB_WHITE);
		// Window edge at zero, so it covers every pixel from window column 7 on,
		// and coordinates far off the screen.
		add_regs(8'h21, 8'd0, 8'd0, 8'hE4, 8'd0, 8'd0, 1'b0);
		add_render(8'd255, 8'd255, 8'd143);
		add_render(8'd0, 8'd0, 8'd0);

		foreach (steps[i]) begin
			if (steps[i].kind == STEP_REGS) begin
				load_registers(steps[i].regs);
			end else begin
				send_request(steps[i].req, steps[i].known, steps[i].want);
			end
		end

		// Random part, in phases with a fresh register setting each. The first
		// two phases take the extremes: every register bit set, then all clear.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				regs = '1;
			end else if (phase == 1) begin
				regs = '0;
			end else begin
				regs.lcdc = 8'($urandom_range(0, 255));
				// Mostly keep the background on so that pixels carry tile data.
				if ($urandom_range(0, 4) != 0) regs.lcdc[LCDC_BG_ON] = 1'b1;
				regs.scx = 8'($urandom_range(0, 255));
				regs.scy = 8'($urandom_range(0, 255));
				regs.pal = 8'($urandom_range(0, 255));
				regs.wx = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 166)
					: $urandom_range(0, 255));
				regs.wy = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 143)
					: $urandom_range(0, 255));
				regs.green = 1'($urandom_range(0, 1));
			end
			load_registers(regs);

			// A few hot tiles per phase. Tile 0 is among them because every map
			// entry that was never written points at it; 0x80 sits at the seam
			// between the signed and unsigned areas.
			hot = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h80, 8'h00};

			repeat (PHASE_REQUESTS) begin
				req.vram_addr = 13'($urandom_range(0, VRAM_BYTES - 1));
				req.vram_data = 8'($urandom_range(0, 255));
				req.line = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 143));
				req.screen_x = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 159));
				req.window_line = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 143));
				if ($urandom_range(0, 99) < 35) begin
					req.op = OP_WRITE;
					pick = $urandom_range(0, 99);
					tile = hot[2'($urandom_range(0, 3))];
					if (pick < 45) begin
						// A byte of a hot tile, in either addressing mode.
						if ($urandom_range(0, 1) == 1) begin
							req.vram_addr = {1'b0, tile, 4'($urandom_range(0, 15))};
						end else begin
							req.vram_addr = TILE_SIGNED_BASE +
								{1'b0, tile ^ SIGN_FLIP, 4'($urandom_range(0, 15))};
						end
					end else if (pick < 75) begin
						// A map entry, mostly pointing at a hot tile.
						req.vram_addr = MAP_LOW_BASE + 13'($urandom_range(0, 2047));
						if ($urandom_range(0, 3) != 0) req.vram_data = tile;
					end
				end else begin
					req.op = OP_RENDER;
				end
				send_request(req, 1'b0, '0);
			end
		end

		// Drain: wait for every pixel, then linger for anything stray to show up.
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		fault_count += pending_pixels.size();
		if (fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tbwp_pkg.sv
rtl/core/tile_background_window_pixel.sv
tb/tile_background_window_pixel_test.sv
